>>> rtl/madf_pkg.sv
`default_nettype none

package madf_pkg;

    localparam int unsigned DEFAULT_WINDOW = 16;

    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned LEVEL_W  = 11;
    localparam int unsigned DEV_W    = 11;
    localparam int unsigned CHAN_W   = 2;

    localparam logic [SAMPLE_W-1:0] RING_INIT    = SAMPLE_W'(511);
    localparam logic [SAMPLE_W-1:0] THRESH_RESET = SAMPLE_W'(100);
    localparam logic [LEVEL_W-1:0]  FULL_LEVEL   = LEVEL_W'(1024);
    localparam logic [CHAN_W-1:0]   LATEST_CHAN  = CHAN_W'(0);

    // floor(9*x/10) == (x * 9 * 13108) >> 17, exact for 9*x < 16384
    localparam int unsigned DECAY_MUL   = 117972;
    localparam int unsigned DECAY_MUL_W = 17;
    localparam int unsigned DECAY_SHIFT = 17;
    localparam int unsigned DECAY_PROD_W = LEVEL_W + DECAY_MUL_W;

    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_TICK   = 1'b1
    } func_t;

    function automatic logic [LEVEL_W-1:0] decay_level(input logic [LEVEL_W-1:0] lvl);
        logic [DECAY_PROD_W-1:0] prod;
        prod = DECAY_PROD_W'(lvl) * DECAY_PROD_W'(DECAY_MUL);
        return prod[DECAY_SHIFT +: LEVEL_W];
    endfunction

endpackage

`default_nettype wire

>>> rtl/moving_average_deviation_flash_core.sv
// Output: a frame tick beat's result shows on m_* in the cycle after acceptance.
// Throughput: one beat per cycle on s_*; the output register is refilled in the
//   cycle it drains, so the input stalls only while m_valid is high and m_ready low.
// Reset (aresetn low, synchronous): ring reads as 511 everywhere via per-entry
//   valid bits, threshold 100, level/latest/average 0. No clearing pass.
`default_nettype none

module moving_average_deviation_flash_core #(
    parameter int unsigned WINDOW = madf_pkg::DEFAULT_WINDOW
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             cfg_wr_en,
    input  wire logic [madf_pkg::SAMPLE_W-1:0]    cfg_wr_data,

    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_func,
    input  wire logic [madf_pkg::CHAN_W-1:0]      s_channel,
    input  wire logic [madf_pkg::SAMPLE_W-1:0]    s_sample,

    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [madf_pkg::LEVEL_W-1:0]          m_drive_level,
    output logic signed [madf_pkg::DEV_W-1:0]     m_deviation,
    output logic                                  m_triggered
);
    import madf_pkg::*;

    // Window geometry
    localparam int unsigned SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned TOTAL_W = $clog2(WINDOW * 1023 + 1);

    // Average by reciprocal: q = (total * RECIP) >> (TOTAL_W + SLOT_W), exact
    // for any TOTAL_W-bit total with RECIP = ceil(2^(TOTAL_W+SLOT_W) / WINDOW).
    localparam int unsigned AVG_SHIFT = TOTAL_W + SLOT_W;
    localparam int unsigned RECIP_W   = TOTAL_W + 1;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << AVG_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];
    localparam int unsigned PROD_W = TOTAL_W + RECIP_W;

    localparam logic [TOTAL_W-1:0] TOTAL_INIT = TOTAL_W'(511 * WINDOW);
    localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(WINDOW - 1);

    // Handshake
    logic accept;
    logic is_tick;
    logic is_sample;

    // State
    logic [SAMPLE_W-1:0] thresh_reg;
    logic [SAMPLE_W-1:0] latest_reg,  latest_next;
    logic [TOTAL_W-1:0]  total_reg,   total_next;
    logic [SLOT_W-1:0]   slot_reg,    slot_next;
    logic                avg_live_reg;          // average is 0 until first sample
    logic [LEVEL_W-1:0]  level_reg,   level_next;

    // Ring: memory plus per-entry valid bits; read data is for the slot to be
    // overwritten next (prefetched one sample ahead).
    logic [SAMPLE_W-1:0] ring_mem [WINDOW];
    logic [WINDOW-1:0]   ring_valid_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_valid_reg;
    logic [SAMPLE_W-1:0] oldest;

    // Datapath
    logic [PROD_W-1:0]         avg_prod;
    logic [SAMPLE_W-1:0]       average;
    logic signed [DEV_W-1:0]   dev;
    logic signed [DEV_W-1:0]   dev_abs;
    logic [SAMPLE_W-1:0]       mag;
    logic                      trig;

    // Output register
    logic                      m_valid_reg;
    logic [LEVEL_W-1:0]        m_level_reg;
    logic signed [DEV_W-1:0]   m_dev_reg;
    logic                      m_trig_reg;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign is_tick   = (func_t'(s_func) == FUNC_TICK);
    assign is_sample = (func_t'(s_func) == FUNC_SAMPLE);

    // Sample path: latest first, then push it, total = total - oldest + latest
    assign oldest      = rd_valid_reg ? rd_data_reg : RING_INIT;
    assign latest_next = (s_channel == LATEST_CHAN) ? s_sample : latest_reg;
    assign total_next  = total_reg - TOTAL_W'(oldest) + TOTAL_W'(latest_next);
    assign slot_next   = (slot_reg == SLOT_LAST) ? '0 : slot_reg + SLOT_W'(1);

    // Tick path: average from the registered total, deviation, compare
    assign avg_prod = PROD_W'(total_reg) * PROD_W'(RECIP);
    assign average  = avg_live_reg ? avg_prod[AVG_SHIFT +: SAMPLE_W] : '0;
    assign dev      = $signed({1'b0, latest_reg}) - $signed({1'b0, average});
    assign dev_abs  = dev[DEV_W-1] ? -dev : dev;
    assign mag      = dev_abs[SAMPLE_W-1:0];
    assign trig     = (mag > thresh_reg);
    assign level_next = trig ? FULL_LEVEL : decay_level(level_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg     <= THRESH_RESET;
            latest_reg     <= '0;
            total_reg      <= TOTAL_INIT;
            slot_reg       <= '0;
            avg_live_reg   <= 1'b0;
            level_reg      <= '0;
            ring_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                thresh_reg <= cfg_wr_data;
            end
            if (accept && is_sample) begin
                latest_reg               <= latest_next;
                total_reg                <= total_next;
                slot_reg                 <= slot_next;
                avg_live_reg             <= 1'b1;
                ring_valid_reg[slot_reg] <= 1'b1;
                rd_valid_reg             <= ring_valid_reg[slot_next];
            end
            // a tick refills the output register, else a drained beat empties it
            if (accept && is_tick) begin
                level_reg   <= level_next;
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Ring storage and prefetch read; slot_next differs from slot_reg whenever WINDOW > 1
    always_ff @(posedge aclk) begin
        if (accept && is_sample) begin
            ring_mem[slot_reg] <= latest_next;
            rd_data_reg        <= ring_mem[slot_next];
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept && is_tick) begin
            m_level_reg <= level_next;
            m_dev_reg   <= dev;
            m_trig_reg  <= trig;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_drive_level = m_level_reg;
    assign m_deviation   = m_dev_reg;
    assign m_triggered   = m_trig_reg;

`ifndef SYNTH
    // Trigger forces full level; decay never reaches full
    a_trig_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_triggered |-> m_drive_level == FULL_LEVEL)
        else $error("triggered beat without full level");

    a_decay_below: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_triggered |-> m_drive_level < FULL_LEVEL)
        else $error("untriggered beat at or above full level");

    // A sample beat never produces a result
    a_sample_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_sample && !m_valid_reg |=> !m_valid_reg)
        else $error("sample beat raised m_valid");

    // Running total stays within the window's range
    a_total_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(total_reg) <= WINDOW * 1023)
        else $error("window total out of range");

    // Level register mirrors the last emitted beat
    a_level_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_level_reg == level_reg)
        else $error("output level differs from level state");
`endif

endmodule

`default_nettype wire

>>> test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import madf_pkg::*;

    // Window depth of the instance; the detector copy below tracks the same ring.
    localparam int unsigned WINDOW = DEFAULT_WINDOW;

    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 4;     // tick result shows in the cycle after accept
    localparam int HOLD_CYCLES    = 400;   // long sink hold-off, fills the output reg
    localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before we call it hung
    localparam int PHASES         = 6;
    localparam int BEATS_PER_PHASE = 246;
    localparam int HOLD_PHASE     = 2;
    localparam int PRINT_LIMIT    = 30;

    // One input beat, as seen on the s_ side.
    typedef struct packed {
        func_t                 func;
        logic [CHAN_W-1:0]     chan;
        logic [SAMPLE_W-1:0]   smp;
    } beat_t;

    // One tick result, as seen on the m_ side.
    typedef struct packed {
        logic [LEVEL_W-1:0]        level;
        logic signed [DEV_W-1:0]   dev;
        logic                      trig;
    } flash_t;

    // Directed row: a beat plus an optional hand-written result.
    typedef struct packed {
        beat_t   beat;
        logic    typed;
        flash_t  want;
    } row_t;

    localparam flash_t NO_FLASH = '0;
    localparam int DIRECTED_N = 22;

    // Directed sequence, threshold at its reset value (100).
    // Only the very first tick has a typed result: nothing sampled yet, so
    // the average is still 0, latest is 0, and the level stays 0.
    row_t directed_rows [DIRECTED_N] = '{
        '{'{FUNC_TICK,   2'd0, 10'd0},    1'b1, '{11'd0, 11'sd0, 1'b0}},
        '{'{FUNC_SAMPLE, 2'd1, 10'd1023}, 1'b0, NO_FLASH},  // ch1: latest stays 0
        '{'{FUNC_TICK,   2'd3, 10'd1023}, 1'b0, NO_FLASH},  // tick ignores chan/sample
        '{'{FUNC_SAMPLE, 2'd0, 10'd1023}, 1'b0, NO_FLASH},  // full-scale sample
        '{'{FUNC_TICK,   2'd0, 10'd0},    1'b0, NO_FLASH},
        '{'{FUNC_SAMPLE, 2'd3, 10'd0},    1'b0, NO_FLASH},  // ch3 still pushes latest
        '{'{FUNC_SAMPLE, 2'd2, 10'd1023}, 1'b0, NO_FLASH},
        '{'{FUNC_TICK,   2'd2, 10'h2AA},  1'b0, NO_FLASH},
        '{'{FUNC_TICK,   2'd1, 10'h155},  1'b0, NO_FLASH},
        '{'{FUNC_SAMPLE, 2'd0, 10'd0},    1'b0, NO_FLASH},  // drop to zero: big negative dev
        '{'{FUNC_TICK,   2'd0, 10'd0},    1'b0, NO_FLASH},
        '{'{FUNC_SAMPLE, 2'd0, 10'h2AA},  1'b0, NO_FLASH},
        '{'{FUNC_SAMPLE, 2'd0, 10'h155},  1'b0, NO_FLASH},
        '{'{FUNC_SAMPLE, 2'd0, 10'd512},  1'b0, NO_FLASH},
        '{'{FUNC_SAMPLE, 2'd0, 10'd511},  1'b0, NO_FLASH},
        '{'{FUNC_TICK,   2'd0, 10'd0},    1'b0, NO_FLASH},
        '{'{FUNC_TICK,   2'd0, 10'd0},    1'b0, NO_FLASH},  // decay steps
        '{'{FUNC_TICK,   2'd0, 10'd0},    1'b0, NO_FLASH},
        '{'{FUNC_SAMPLE, 2'd0, 10'd0},    1'b0, NO_FLASH},
        '{'{FUNC_TICK,   2'd0, 10'd0},    1'b0, NO_FLASH},
        '{'{FUNC_SAMPLE, 2'd0, 10'd1023}, 1'b0, NO_FLASH},
        '{'{FUNC_TICK,   2'd3, 10'd0},    1'b0, NO_FLASH}
    };

    // ---------------------------------------------------------------
    // DUT ports; every input is known from time zero
    // ---------------------------------------------------------------
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [SAMPLE_W-1:0]   cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_func = 1'b0;
    logic [CHAN_W-1:0]     s_channel = '0;
    logic [SAMPLE_W-1:0]   s_sample = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [LEVEL_W-1:0]    m_drive_level;
    logic signed [DEV_W-1:0] m_deviation;
    logic                  m_triggered;

    moving_average_deviation_flash_core #(
        .WINDOW (WINDOW)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_channel     (s_channel),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive_level (m_drive_level),
        .m_deviation   (m_deviation),
        .m_triggered   (m_triggered)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Detector copy: ring, running sum, floor average, latest, level
    // ---------------------------------------------------------------
    logic [SAMPLE_W-1:0]  window_ring [WINDOW];
    int unsigned          ring_slot;
    logic [13:0]          window_sum;
    logic [SAMPLE_W-1:0]  window_mean;
    logic [SAMPLE_W-1:0]  axis_latest;
    logic [LEVEL_W-1:0]   drive_now;
    logic [SAMPLE_W-1:0]  threshold_now;

    flash_t pending_flashes [$];   // tick results still owed by the DUT

    // shared knobs between stimulus, sink and checker
    bit idle_enable   = 1'b1;
    bit hold_request  = 1'b0;
    int error_count   = 0;
    int sample_count  = 0;
    int tick_count    = 0;
    int flash_count   = 0;
    int checked_count = 0;
    int quiet_level   = 511;        // slow-moving baseline for the random samples

    // Advance the detector copy by one accepted beat. A tick yields a result.
    task automatic predict_flash(input beat_t b, output bit has_result, output flash_t r);
        int dev;
        int mag;
        has_result = 1'b0;
        r = '0;
        if (b.func == FUNC_SAMPLE) begin
            if (b.chan == LATEST_CHAN) begin
                axis_latest = b.smp;
            end
            // the running sum never underflows: it always holds the ring entry
            window_sum = window_sum - 14'(window_ring[ring_slot]) + 14'(axis_latest);
            window_ring[ring_slot] = axis_latest;
            ring_slot = (ring_slot + 1) % WINDOW;
            window_mean = SAMPLE_W'(window_sum / WINDOW);
        end else begin
            dev = int'(axis_latest) - int'(window_mean);
            mag = (dev < 0) ? -dev : dev;
            r.trig = (mag > int'(threshold_now));
            if (r.trig) begin
                drive_now = FULL_LEVEL;
            end else begin
                drive_now = LEVEL_W'((int'(drive_now) * 9) / 10);
            end
            r.level = drive_now;
            r.dev = DEV_W'(dev);
            has_result = 1'b1;
        end
    endtask

    // Offer one beat, hold it until accepted, then book the expected result.
    task automatic send_beat(input beat_t b, input bit typed, input flash_t want,
                             input bit may_idle);
        bit     has_result;
        flash_t r;
        s_valid   <= 1'b1;
        s_func    <= b.func;
        s_channel <= b.chan;
        s_sample  <= b.smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_flash(b, has_result, r);
        if (b.func == FUNC_SAMPLE) begin
            sample_count++;
        end else begin
            tick_count++;
        end
        if (has_result) begin
            if (typed) begin
                r = want;
            end
            if (r.trig) begin
                flash_count++;
            end
            pending_flashes.push_back(r);
        end
        // random gap burst on the source side
        if (may_idle && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    // Threshold writes happen only with the DUT drained.
    task automatic set_threshold(input logic [SAMPLE_W-1:0] value);
        while (pending_flashes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        threshold_now = value;
    endtask

    // Random beat: mostly channel-0 samples hovering near a baseline, with
    // spikes, rail values, baseline jumps, other channels and ~25% ticks.
    task automatic next_beat(output beat_t b);
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            b.func = FUNC_TICK;
            b.chan = CHAN_W'($urandom);
            b.smp  = SAMPLE_W'($urandom);
        end else begin
            b.func = FUNC_SAMPLE;
            b.chan = ($urandom_range(0, 9) < 7) ? LATEST_CHAN : CHAN_W'($urandom_range(1, 3));
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                v = quiet_level + $urandom_range(0, 60) - 30;
                if (v < 0) v = 0;
                if (v > 1023) v = 1023;
                b.smp = SAMPLE_W'(v);
            end else if (pick < 16) begin
                b.smp = SAMPLE_W'($urandom);
            end else if (pick < 18) begin
                b.smp = (pick == 16) ? '0 : '1;
            end else begin
                quiet_level = $urandom_range(0, 1023);
                b.smp = SAMPLE_W'(quiet_level);
            end
        end
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // ---------------------------------------------------------------
    // Result checker: every m_ beat against the oldest expectation
    // ---------------------------------------------------------------
    flash_t oldest;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_flashes.size() == 0) begin
                report_mismatch("unexpected result beat, level", -1, int'(m_drive_level));
            end else begin
                oldest = pending_flashes.pop_front();
                checked_count++;
                if (m_drive_level !== oldest.level) begin
                    report_mismatch("drive_level", int'(oldest.level), int'(m_drive_level));
                end
                if (m_deviation !== oldest.dev) begin
                    report_mismatch("deviation", int'(oldest.dev), int'(m_deviation));
                end
                if (m_triggered !== oldest.trig) begin
                    report_mismatch("triggered", int'(oldest.trig), int'(m_triggered));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result sink: random stall bursts, plus one long hold-off on request
    // ---------------------------------------------------------------
    initial begin : sink
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                // long back-pressure: the output reg fills and s_ready drops
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (idle_enable && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: too long without any beat on either side means a hang
    // ---------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: watchdog expired, %0d results still pending", $time,
                 pending_flashes.size());
        $display("** moving_average_deviation_flash_core: FAILED **");
        $finish;
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    logic [SAMPLE_W-1:0] phase_thresh [PHASES];

    initial begin : stimulus
        beat_t b;
        int    p;

        // detector copy starts from the post-reset state
        foreach (window_ring[i]) window_ring[i] = RING_INIT;
        ring_slot     = 0;
        window_sum    = 14'(int'(RING_INIT) * WINDOW);
        window_mean   = '0;
        axis_latest   = '0;
        drive_now     = '0;
        threshold_now = THRESH_RESET;

        // threshold sweep: both rails, a tiny one, random picks, mid-scale
        phase_thresh[0] = '0;
        phase_thresh[1] = '1;
        phase_thresh[2] = SAMPLE_W'($urandom);
        phase_thresh[3] = SAMPLE_W'(1);
        phase_thresh[4] = SAMPLE_W'($urandom);
        phase_thresh[5] = SAMPLE_W'(511);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows at the reset threshold, written explicitly anyway
        set_threshold(THRESH_RESET);
        foreach (directed_rows[i]) begin
            send_beat(directed_rows[i].beat, directed_rows[i].typed,
                      directed_rows[i].want, 1'b1);
        end
        s_valid <= 1'b0;

        // random phases, each under its own threshold
        for (p = 0; p < PHASES; p++) begin
            set_threshold(phase_thresh[p]);
            if (p == PHASES - 1) begin
                idle_enable = 1'b0;   // closing stretch runs at full rate
            end
            if (p == HOLD_PHASE) begin
                hold_request = 1'b1;
            end
            repeat (BEATS_PER_PHASE) begin
                next_beat(b);
                send_beat(b, 1'b0, NO_FLASH, idle_enable);
            end
            s_valid <= 1'b0;
        end

        // drain, then give stray results a chance to show up
        while (pending_flashes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("run: %0d sample beats, %0d tick beats, %0d results checked (%0d flashes)",
                 sample_count, tick_count, checked_count, flash_count);
        $display("run: %0d threshold settings incl. 0 and 1023, one %0d-cycle sink hold-off",
                 PHASES + 1, HOLD_CYCLES);
        if (error_count == 0) begin
            $display("** moving_average_deviation_flash_core: PASSED **");
        end else begin
            $display("** moving_average_deviation_flash_core: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/madf_pkg.sv
rtl/moving_average_deviation_flash_core.sv
test/tb_top.sv
